### design/derb_pkg.sv
package derb_pkg;

   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = ADDR_W + 1;

   typedef enum logic [2:0] {
      KIND_PUSH_BACK  = 3'd0,
      KIND_PUSH_FRONT = 3'd1,
      KIND_POP_BACK   = 3'd2,
      KIND_POP_FRONT  = 3'd3,
      KIND_READ_IDX   = 3'd4,
      KIND_WRITE_IDX  = 3'd5,
      KIND_CLEAR      = 3'd6,
      KIND_NOP        = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_RANGE = 2'd2,
      STATUS_RSVD  = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] value;
      logic [5:0]  position;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [1:0]  status;
      logic [6:0]  occupancy;
      logic        overwrote;
   } rsp_type;

endpackage

### design/double_ended_ring_buffer.sv
// Double-ended ring buffer with overwrite. Pulse start with a command in req_data while
// busy is low; exactly one result comes back on rsp_data with rsp_valid high for one cycle,
// and it must be taken then since the block cannot be stalled. Pushes, indexed writes,
// clear, no-ops and error results show in the cycle after start, and a new command may
// follow at once. Pops and indexed reads pass through the read state, because the slot
// store is a single-port synchronous RAM with a registered read output; busy is high
// in the read state. A push on a full ring replaces the element at the opposite end.
// Writing csr_wr_data sets the ring capacity (0 reads as 1, above 64 saturates to 64) and
// empties the ring; write it only while no command is outstanding.
module double_ended_ring_buffer (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  derb_pkg::req_type req_data,
   output logic              rsp_valid,
   output derb_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [6:0]        csr_wr_data
);

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   state_type                     state_ff, state_in;
   logic [derb_pkg::ADDR_W-1:0]   head_ff, head_in;
   logic [derb_pkg::CNT_W-1:0]    fill_ff, fill_in;
   logic [derb_pkg::CNT_W-1:0]    cap_ff, cap_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   derb_pkg::rsp_type             rsp_ff, rsp_in;

   logic [31:0]                   slots [derb_pkg::DEPTH];
   logic [31:0]                   mem_q_ff;
   logic                          mem_we, mem_re;
   logic [derb_pkg::ADDR_W-1:0]   mem_addr;
   logic [31:0]                   mem_wdata;

   logic                          accept;
   logic                          full;
   logic [derb_pkg::CNT_W-1:0]    pos_ext;
   logic [derb_pkg::ADDR_W-1:0]   head_prev;
   logic [derb_pkg::CNT_W-1:0]    cap_sat;

   function automatic logic [derb_pkg::ADDR_W-1:0] wrap_add(
      input logic [derb_pkg::ADDR_W-1:0] base,
      input logic [derb_pkg::CNT_W-1:0]  off,
      input logic [derb_pkg::CNT_W-1:0]  cap
   );
      logic [derb_pkg::CNT_W-1:0] sum;
      sum = {1'b0, base} + off;
      if (sum >= cap) begin
         sum = sum - cap;
      end
      return sum[derb_pkg::ADDR_W-1:0];
   endfunction

   assign busy      = (state_ff == ST_READ);
   assign accept    = start && !busy;
   assign full      = (fill_ff >= cap_ff);
   assign pos_ext   = derb_pkg::CNT_W'(req_data.position);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      head_prev = (head_ff == '0) ? derb_pkg::ADDR_W'(cap_ff - 1'b1) : head_ff - 1'b1;
      if (csr_wr_data == '0) begin
         cap_sat = derb_pkg::CNT_W'(1);
      end else if (derb_pkg::CNT_W'(csr_wr_data) > derb_pkg::CNT_W'(derb_pkg::DEPTH)) begin
         cap_sat = derb_pkg::CNT_W'(derb_pkg::DEPTH);
      end else begin
         cap_sat = derb_pkg::CNT_W'(csr_wr_data);
      end
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      cap_in       = cap_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = head_ff;
      mem_wdata    = req_data.value;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_in.read_data = '0;
               rsp_in.status    = derb_pkg::STATUS_OK;
               rsp_in.overwrote = 1'b0;
               rsp_valid_in     = 1'b1;
               unique case (derb_pkg::kind_type'(req_data.kind))
                  derb_pkg::KIND_PUSH_BACK: begin
                     mem_we = 1'b1;
                     if (full) begin
                        head_in          = wrap_add(head_ff, derb_pkg::CNT_W'(1), cap_ff);
                        rsp_in.overwrote = 1'b1;
                     end else begin
                        mem_addr = wrap_add(head_ff, fill_ff, cap_ff);
                        fill_in  = fill_ff + 1'b1;
                     end
                  end
                  derb_pkg::KIND_PUSH_FRONT: begin
                     mem_we   = 1'b1;
                     mem_addr = head_prev;
                     head_in  = head_prev;
                     if (full) begin
                        rsp_in.overwrote = 1'b1;
                     end else begin
                        fill_in = fill_ff + 1'b1;
                     end
                  end
                  derb_pkg::KIND_POP_BACK: begin
                     if (fill_ff == '0) begin
                        rsp_in.status = derb_pkg::STATUS_EMPTY;
                     end else begin
                        mem_re       = 1'b1;
                        mem_addr     = wrap_add(head_ff, fill_ff - 1'b1, cap_ff);
                        fill_in      = fill_ff - 1'b1;
                        rsp_valid_in = 1'b0;
                        state_in     = ST_READ;
                     end
                  end
                  derb_pkg::KIND_POP_FRONT: begin
                     if (fill_ff == '0) begin
                        rsp_in.status = derb_pkg::STATUS_EMPTY;
                     end else begin
                        mem_re       = 1'b1;
                        head_in      = wrap_add(head_ff, derb_pkg::CNT_W'(1), cap_ff);
                        fill_in      = fill_ff - 1'b1;
                        rsp_valid_in = 1'b0;
                        state_in     = ST_READ;
                     end
                  end
                  derb_pkg::KIND_READ_IDX: begin
                     if (pos_ext >= fill_ff) begin
                        rsp_in.status = derb_pkg::STATUS_RANGE;
                     end else begin
                        mem_re       = 1'b1;
                        mem_addr     = wrap_add(head_ff, pos_ext, cap_ff);
                        rsp_valid_in = 1'b0;
                        state_in     = ST_READ;
                     end
                  end
                  derb_pkg::KIND_WRITE_IDX: begin
                     if (pos_ext >= fill_ff) begin
                        rsp_in.status = derb_pkg::STATUS_RANGE;
                     end else begin
                        mem_we   = 1'b1;
                        mem_addr = wrap_add(head_ff, pos_ext, cap_ff);
                     end
                  end
                  derb_pkg::KIND_CLEAR: begin
                     fill_in = '0;
                  end
                  default: begin
                  end
               endcase
               rsp_in.occupancy = 7'(fill_in);
            end
         end
         ST_READ: begin
            // pointers already advanced; the slot arrives from the RAM this cycle
            rsp_in.read_data = mem_q_ff;
            rsp_in.status    = derb_pkg::STATUS_OK;
            rsp_in.occupancy = 7'(fill_ff);
            rsp_in.overwrote = 1'b0;
            rsp_valid_in     = 1'b1;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         cap_in  = cap_sat;
         head_in = '0;
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         cap_ff       <= derb_pkg::CNT_W'(derb_pkg::DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slots[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= slots[mem_addr];
      end
   end

endmodule

### design/derb_checker.sv
module derb_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input derb_pkg::rsp_type rsp_data
);

   // every accepted item yields a result next cycle or raises busy for a RAM read
   a_accept_answer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted item produced neither result nor busy");

   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> (!busy && rsp_valid))
      else $error("read cycle did not end in a result");

   a_error_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != derb_pkg::STATUS_OK) |-> (rsp_data.read_data == '0))
      else $error("error result carries data");

   a_overwrite_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.overwrote) |->
         (rsp_data.status == derb_pkg::STATUS_OK && rsp_data.read_data == '0
          && rsp_data.occupancy != '0))
      else $error("overwrite result is malformed");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.occupancy <= 7'(derb_pkg::DEPTH)))
      else $error("occupancy beyond depth");

endmodule

bind double_ended_ring_buffer derb_checker u_derb_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

### dv/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 125;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      derb_pkg::req_type r;
      bit                aim;   // pick an occupied position when the item is issued
   } cmd_slot_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   derb_pkg::req_type req_data = '0;
   logic              rsp_valid;
   derb_pkg::rsp_type rsp_data;
   logic              csr_wr_en = 1'b0;
   logic [6:0]        csr_wr_data = '0;

   double_ended_ring_buffer dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // ring as the block should hold it
   logic [31:0] ring_mem [derb_pkg::DEPTH];
   int          ring_head = 0;
   int          ring_fill = 0;
   int          ring_cap  = derb_pkg::DEPTH;

   cmd_slot_type      pending_cmds [$];
   derb_pkg::rsp_type predicted_rsps [$];

   bit steady_phase = 1'b0;
   int idle_left    = 0;
   int cycle_count  = 0;
   int items_sent   = 0;
   int rsps_checked = 0;
   int mismatches   = 0;
   int n_overwrite  = 0;
   int n_empty_pop  = 0;
   int n_range      = 0;
   int n_settings   = 1;

   function automatic derb_pkg::rsp_type deque_apply(derb_pkg::req_type r);
      derb_pkg::rsp_type o;
      logic              full;
      int                slot;
      o = '0;
      full = (ring_fill >= ring_cap);
      case (derb_pkg::kind_type'(r.kind)) inside
         derb_pkg::KIND_PUSH_BACK: begin
            if (full) begin
               ring_mem[ring_head] = r.value;
               ring_head = (ring_head + 1) % ring_cap;
               o.overwrote = 1'b1;
            end else begin
               ring_mem[(ring_head + ring_fill) % ring_cap] = r.value;
               ring_fill++;
            end
         end
         derb_pkg::KIND_PUSH_FRONT: begin
            ring_head = (ring_head + ring_cap - 1) % ring_cap;
            ring_mem[ring_head] = r.value;
            if (full)
               o.overwrote = 1'b1;
            else
               ring_fill++;
         end
         derb_pkg::KIND_POP_BACK: begin
            if (ring_fill == 0) begin
               o.status = derb_pkg::STATUS_EMPTY;
            end else begin
               o.read_data = ring_mem[(ring_head + ring_fill - 1) % ring_cap];
               ring_fill--;
            end
         end
         derb_pkg::KIND_POP_FRONT: begin
            if (ring_fill == 0) begin
               o.status = derb_pkg::STATUS_EMPTY;
            end else begin
               o.read_data = ring_mem[ring_head];
               ring_head = (ring_head + 1) % ring_cap;
               ring_fill--;
            end
         end
         derb_pkg::KIND_READ_IDX, derb_pkg::KIND_WRITE_IDX: begin
            if (int'(r.position) >= ring_fill) begin
               o.status = derb_pkg::STATUS_RANGE;
            end else begin
               slot = (ring_head + int'(r.position)) % ring_cap;
               if (r.kind == derb_pkg::KIND_READ_IDX)
                  o.read_data = ring_mem[slot];
               else
                  ring_mem[slot] = r.value;
            end
         end
         derb_pkg::KIND_CLEAR: begin
            ring_fill = 0;
         end
         default: begin
         end
      endcase
      o.occupancy = 7'(ring_fill);
      return o;
   endfunction

   function automatic int pick_gap();
      int r;
      if (steady_phase)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [2:0] pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return derb_pkg::KIND_PUSH_BACK;
      if (r < 50) return derb_pkg::KIND_PUSH_FRONT;
      if (r < 62) return derb_pkg::KIND_POP_BACK;
      if (r < 74) return derb_pkg::KIND_POP_FRONT;
      if (r < 84) return derb_pkg::KIND_READ_IDX;
      if (r < 94) return derb_pkg::KIND_WRITE_IDX;
      if (r < 97) return derb_pkg::KIND_CLEAR;
      return derb_pkg::KIND_NOP;
   endfunction

   task automatic queue_cmd(input logic [2:0] kind, input logic [31:0] value,
                            input logic [5:0] position, input bit aim);
      cmd_slot_type c;
      c.r.kind     = kind;
      c.r.value    = value;
      c.r.position = position;
      c.aim        = aim;
      pending_cmds = {pending_cmds, c};
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() != 0 || start || predicted_rsps.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [6:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      ring_cap  = (v == 0) ? 1 : ((int'(v) > derb_pkg::DEPTH) ? derb_pkg::DEPTH : int'(v));
      ring_head = 0;
      ring_fill = 0;
      n_settings++;
   endtask

   // driver: issue items, predict each one as it is taken
   always @(posedge clock) begin
      cmd_slot_type      nxt;
      derb_pkg::rsp_type pred;
      if (reset) begin
         start <= 1'b0;
         idle_left = 0;
      end else if (!start || !busy) begin
         if (start) begin
            pred = deque_apply(req_data);
            predicted_rsps = {predicted_rsps, pred};
            items_sent++;
            if (pred.overwrote) n_overwrite++;
            if (pred.status == derb_pkg::STATUS_EMPTY) n_empty_pop++;
            if (pred.status == derb_pkg::STATUS_RANGE) n_range++;
            idle_left = pick_gap();
         end else if (idle_left > 0) begin
            idle_left--;
         end
         if (idle_left == 0 && pending_cmds.size() != 0) begin
            nxt = pending_cmds[0];
            pending_cmds.delete(0);
            if (nxt.aim && ring_fill > 0 &&
                (nxt.r.kind == derb_pkg::KIND_READ_IDX ||
                 nxt.r.kind == derb_pkg::KIND_WRITE_IDX))
               nxt.r.position = 6'($urandom_range(0, ring_fill - 1));
            req_data <= nxt.r;
            start    <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: every strobed result against the oldest prediction
   always @(posedge clock) begin
      derb_pkg::rsp_type exp_rsp;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (predicted_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: unexpected result %p", $realtime, rsp_data);
            end else begin
               exp_rsp = predicted_rsps[0];
               predicted_rsps.delete(0);
               rsps_checked++;
               if (rsp_data !== exp_rsp) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display({"%0t: result %0d mismatch: data %h/%h status %0d/%0d",
                               " occ %0d/%0d ovw %0b/%0b (exp/act)"},
                              $realtime, rsps_checked,
                              exp_rsp.read_data, rsp_data.read_data,
                              exp_rsp.status, rsp_data.status,
                              exp_rsp.occupancy, rsp_data.occupancy,
                              exp_rsp.overwrote, rsp_data.overwrote);
               end
            end
         end else if (rsp_valid !== 1'b0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: rsp_valid unknown", $realtime);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timed out with %0d results outstanding", predicted_rsps.size());
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      logic [6:0] caps [12];
      int         burst;
      caps = '{7'd2, 7'd0, 7'd1, 7'd3, 7'd64, 7'd127, 7'd5, 7'd65, 7'd63, 7'd16,
               7'd9, 7'd100};
      caps[10] = 7'($urandom_range(1, 127));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed pass at the reset capacity, ring starts empty
      queue_cmd(derb_pkg::KIND_POP_BACK,   32'h0, 6'd0, 1'b0);
      queue_cmd(derb_pkg::KIND_POP_FRONT,  32'h0, 6'd0, 1'b0);
      queue_cmd(derb_pkg::KIND_READ_IDX,   32'h0, 6'd0, 1'b0);
      queue_cmd(derb_pkg::KIND_WRITE_IDX,  32'hFFFF_FFFF, 6'd63, 1'b0);
      queue_cmd(derb_pkg::KIND_PUSH_BACK,  32'h0000_0000, 6'd0, 1'b0);
      queue_cmd(derb_pkg::KIND_PUSH_BACK,  32'hFFFF_FFFF, 6'd63, 1'b0);
      queue_cmd(derb_pkg::KIND_PUSH_FRONT, 32'hA5A5_A5A5, 6'd0, 1'b0);
      queue_cmd(derb_pkg::KIND_READ_IDX,   32'h0, 6'd0, 1'b0);
      queue_cmd(derb_pkg::KIND_READ_IDX,   32'h0, 6'd2, 1'b0);
      queue_cmd(derb_pkg::KIND_READ_IDX,   32'h0, 6'd3, 1'b0);
      queue_cmd(derb_pkg::KIND_WRITE_IDX,  32'h5A5A_5A5A, 6'd1, 1'b0);
      queue_cmd(derb_pkg::KIND_READ_IDX,   32'h0, 6'd1, 1'b0);
      queue_cmd(derb_pkg::KIND_NOP,        $urandom, 6'($urandom), 1'b0);
      queue_cmd(derb_pkg::KIND_POP_BACK,   32'h0, 6'd0, 1'b0);
      queue_cmd(derb_pkg::KIND_POP_FRONT,  32'h0, 6'd0, 1'b0);
      queue_cmd(derb_pkg::KIND_CLEAR,      32'h0, 6'd0, 1'b0);
      queue_cmd(derb_pkg::KIND_READ_IDX,   32'h0, 6'd0, 1'b0);
      queue_cmd(derb_pkg::KIND_POP_BACK,   32'h0, 6'd0, 1'b0);
      queue_cmd(derb_pkg::KIND_PUSH_FRONT, 32'h8000_0001, 6'd0, 1'b0);
      queue_cmd(derb_pkg::KIND_PUSH_BACK,  32'h7FFF_FFFE, 6'd0, 1'b0);
      queue_cmd(derb_pkg::KIND_READ_IDX,   32'h0, 6'd63, 1'b0);
      queue_cmd(derb_pkg::KIND_POP_FRONT,  32'h0, 6'd0, 1'b0);
      queue_cmd(derb_pkg::KIND_POP_FRONT,  32'h0, 6'd0, 1'b0);
      queue_cmd(derb_pkg::KIND_POP_FRONT,  32'h0, 6'd0, 1'b0);
      wait_drained();

      foreach (caps[p]) begin
         write_capacity(caps[p]);
         steady_phase = ($urandom_range(0, 3) == 0);
         // fill toward (and past) the capacity, then mix everything
         burst = $urandom_range(0, ring_cap + 4);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i < burst)
               queue_cmd($urandom_range(0, 3) == 0 ? derb_pkg::KIND_PUSH_FRONT
                                                   : derb_pkg::KIND_PUSH_BACK,
                         $urandom, 6'($urandom), 1'b0);
            else
               queue_cmd(pick_kind(), $urandom, 6'($urandom), $urandom_range(0, 4) != 0);
         end
         wait_drained();
      end

      repeat (8) @(posedge clock);
      $display("%0d items over %0d capacity settings, %0d results checked",
               items_sent, n_settings, rsps_checked);
      $display("%0d overwriting pushes, %0d pops on empty, %0d out-of-range accesses",
               n_overwrite, n_empty_pop, n_range);
      if (mismatches == 0 && predicted_rsps.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, predicted_rsps.size());
         $display("FAILURE");
      end
      $finish;
   end

endmodule
